FILE: rtl/gaussian_blur_5x5_edge_normalized_unit_assert.svh
// Assertion macros shared by the blur RTL.
`ifndef GAUSSIAN_BLUR_5X5_EDGE_NORMALIZED_UNIT_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_EDGE_NORMALIZED_UNIT_ASSERT_SVH

`ifndef SYNTH
`define GBU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define GBU_ASSERT_IMP(lbl, ante, cons) \
    `GBU_ASSERT(lbl, (ante) |-> (cons))
`else
`define GBU_ASSERT(lbl, prop)
`define GBU_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

FILE: rtl/gbu_pkg.sv
`timescale 1ns / 1ps
package gbu_pkg;
    localparam int CFG_W_W = 11;
    localparam int CFG_H_W = 13;
    localparam int CFG_D_W = 13;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 32;
    localparam int TAPS    = 5;
    localparam int NUM_W   = 16;  // max 255 * 256
    localparam int DEN_W   = 9;   // max 256
    localparam int WT_W    = 6;   // max 36
    localparam int QBITS   = 8;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    function automatic logic [WT_W-1:0] binom_wt(input logic [2:0] dy, input logic [2:0] dx);
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] k;
        a = 3'd1;
        b = 3'd1;
        for (int i = 0; i < 2; i++) begin
            k = (i == 0) ? dy : dx;
            unique case (k)
                3'd0, 3'd4: if (i == 0) a = 3'd1; else b = 3'd1;
                3'd1, 3'd3: if (i == 0) a = 3'd4; else b = 3'd4;
                3'd2:       if (i == 0) a = 3'd6; else b = 3'd6;
                default:    if (i == 0) a = 3'd0; else b = 3'd0;
            endcase
        end
        return WT_W'(a) * WT_W'(b);
    endfunction
endpackage

FILE: rtl/gbu_ram.sv
`timescale 1ns / 1ps
module gbu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4104
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/gbu_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; quotient known to fit QBITS.
module gbu_div
    import gbu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [CH_W-1:0]  o_quot
);
    logic                      r_busy;
    logic [2:0]                r_bit;
    logic [NUM_W-1:0]          r_rem;
    logic [DEN_W-1:0]          r_den;
    logic [CH_W-1:0]           r_quot;
    logic                      r_done;
    logic [DEN_W+QBITS-1:0]    trial;
    logic                      fits;

    assign trial = (DEN_W+QBITS)'(r_den) << r_bit;
    assign fits  = {1'b0, r_rem} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_bit <= 3'd7;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= NUM_W'({1'b0, r_rem} - trial);
            end
            r_quot[r_bit] <= fits;
            r_bit <= r_bit - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: rtl/gaussian_blur_5x5_edge_normalized_unit.sv
`timescale 1ns / 1ps
// 5x5 binomial blur, taps outside the image dropped and the weights renormalized.
// One item at a time: a pixel is written to the line store on acceptance, then the
// check state decides whether an output is due. If so, the 25 taps are read one
// per cycle from the single line store memory and accumulated, the sums are divided
// bit-serially, and the result is loaded into the output register; only then can the
// next item be accepted. While the output register still holds an unread result, a
// new result waits and the input stays blocked. An item that yields no result returns
// to idle after the check.
// Results wait in an output register; alpha comes from the center pixel.
`include "gaussian_blur_5x5_edge_normalized_unit_assert.svh"
module gaussian_blur_5x5_edge_normalized_unit
    import gbu_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIX_W-1:0]   s_axis_tdata,  // red, green, blue, alpha
    input  logic               s_axis_tuser,  // command
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PIX_W-1:0]   m_axis_tdata,  // red, green, blue, alpha
    output logic               m_axis_tlast,  // last_of_image
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_D_W-1:0] i_cfg_data
);
    localparam int SLOTS = 4 * MAX_WIDTH + 8;
    localparam int AW    = $clog2(SLOTS);
    localparam int XW    = AW + 2;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_READ  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [CW:0]        w_eff;
    logic [RW-1:0]      h_eff;
    logic [31:0]        w32, h32;

    logic [CW-1:0] r_in_col, r_out_col;
    logic [RW-1:0] r_in_row, r_out_row;
    logic [AW-1:0] r_in_addr, r_out_addr, r_tap_addr;

    logic [4:0] r_k;
    logic [2:0] r_dy, r_dx;
    logic       r_p_v, r_p_ctr;
    logic [WT_W-1:0] r_p_wt;
    logic [NUM_W-1:0] r_sum [3];
    logic [DEN_W-1:0] r_total;
    logic [CH_W-1:0]  r_alpha;
    logic [PIX_W-1:0] rd_data;
    logic             div_start, div_done;
    logic [2:0]       div_dones;
    logic [CH_W-1:0]  quot [3];
    logic             in_acc, wr_en, rdy, last;
    logic [RW:0]      need_r, rr_p;
    logic [CW+1:0]    need_c, cc_p;
    logic             tap_ok;
    logic [XW-1:0]    t_next, t_start;

    assign w32 = (r_cfg_w == '0) ? 32'd1 :
                 (32'(r_cfg_w) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(r_cfg_w);
    assign h32 = (r_cfg_h == '0) ? 32'd1 :
                 (32'(r_cfg_h) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(r_cfg_h);
    assign w_eff = w32[CW:0];
    assign h_eff = h32[RW-1:0];

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_we;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign wr_en  = in_acc && (s_axis_tuser == CMD_PIXEL) && (r_in_row < h_eff);

    // next output is ready once the pixel at min(row+2,h-1), min(col+2,w-1) is in
    always_comb begin
        need_r = (RW+1)'(r_out_row) + (RW+1)'(2);
        if (need_r > (RW+1)'(h_eff) - (RW+1)'(1)) need_r = (RW+1)'(h_eff) - (RW+1)'(1);
        need_c = (CW+2)'(r_out_col) + (CW+2)'(2);
        if (need_c > (CW+2)'(w_eff) - (CW+2)'(1)) need_c = (CW+2)'(w_eff) - (CW+2)'(1);
    end
    assign rdy = (r_out_row < h_eff) &&
                 (((RW+1)'(r_in_row) > need_r) ||
                  (((RW+1)'(r_in_row) == need_r) && ((CW+2)'(r_in_col) > need_c)));
    assign last = (r_out_row == h_eff - RW'(1)) && ((CW+1)'(r_out_col) == w_eff - (CW+1)'(1));

    // tap position, shifted by +2 to stay unsigned
    assign rr_p   = (RW+1)'(r_out_row) + (RW+1)'(r_dy);
    assign cc_p   = (CW+2)'(r_out_col) + (CW+2)'(r_dx);
    assign tap_ok = (rr_p >= (RW+1)'(2)) && (rr_p < (RW+1)'(h_eff) + (RW+1)'(2)) &&
                    (cc_p >= (CW+2)'(2)) && (cc_p < (CW+2)'(w_eff) + (CW+2)'(2));

    // ring address walk over the 5x5 window
    always_comb begin
        t_start = XW'(r_out_addr) + XW'(SLOTS) - (XW'(w_eff) * XW'(2) + XW'(2));
        if (t_start >= XW'(SLOTS)) t_start = t_start - XW'(SLOTS);
        if (r_dx == 3'd4) begin
            t_next = XW'(r_tap_addr) + XW'(w_eff) + XW'(SLOTS) - XW'(4);
        end else begin
            t_next = XW'(r_tap_addr) + XW'(1);
        end
        if (t_next >= XW'(2 * SLOTS)) t_next = t_next - XW'(2 * SLOTS);
        else if (t_next >= XW'(SLOTS)) t_next = t_next - XW'(SLOTS);
    end

    gbu_ram #(.WIDTH(PIX_W), .DEPTH(SLOTS)) u_row_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_in_addr),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_tap_addr),
        .o_rdata (rd_data)
    );

    assign div_start = (r_state == S_READ) && (r_k == 5'd25) && !r_p_v;

    for (genvar c = 0; c < 3; c++) begin : g_div
        gbu_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (r_sum[c]),
            .i_den   (r_total),
            .o_done  (div_dones[c]),
            .o_quot  (quot[c])
        );
    end
    assign div_done = &div_dones;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg_w       <= CFG_W_W'(640);
            r_cfg_h       <= CFG_H_W'(480);
            r_in_col      <= '0;
            r_in_row      <= '0;
            r_out_col     <= '0;
            r_out_row     <= '0;
            r_in_addr     <= '0;
            r_out_addr    <= '0;
            r_p_v         <= 1'b0;
            r_k           <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && (r_state != S_OUT)) m_axis_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        unique case (t_reg_idx'(i_cfg_idx))
                            REG_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                            REG_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                        endcase
                        r_in_col   <= '0;
                        r_in_row   <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                        r_in_addr  <= '0;
                        r_out_addr <= '0;
                    end else if (in_acc) begin
                        if (wr_en) begin
                            if ((CW+1)'(r_in_col) + (CW+1)'(1) >= w_eff) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + RW'(1);
                            end else begin
                                r_in_col <= r_in_col + CW'(1);
                            end
                            r_in_addr <= (r_in_addr == AW'(SLOTS - 1)) ? '0 :
                                         r_in_addr + AW'(1);
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (rdy) begin
                        r_state <= S_READ;
                        r_k     <= '0;
                        r_dy    <= '0;
                        r_dx    <= '0;
                        r_tap_addr <= AW'(t_start);
                        r_total <= '0;
                        for (int c = 0; c < 3; c++) r_sum[c] <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (r_k != 5'd25) begin
                        r_p_v   <= 1'b1;
                        r_p_wt  <= tap_ok ? binom_wt(r_dy, r_dx) : '0;
                        r_p_ctr <= (r_dy == 3'd2) && (r_dx == 3'd2);
                        r_k     <= r_k + 5'd1;
                        r_tap_addr <= AW'(t_next);
                        if (r_dx == 3'd4) begin
                            r_dx <= '0;
                            r_dy <= r_dy + 3'd1;
                        end else begin
                            r_dx <= r_dx + 3'd1;
                        end
                    end else if (!r_p_v) begin
                        r_state <= S_DIV;
                    end else begin
                        r_p_v <= 1'b0;
                    end
                    if (r_p_v) begin
                        for (int c = 0; c < 3; c++) begin
                            r_sum[c] <= r_sum[c] +
                                NUM_W'(r_p_wt) * NUM_W'(rd_data[c*CH_W +: CH_W]);
                        end
                        r_total <= r_total + DEN_W'(r_p_wt);
                        if (r_p_ctr) r_alpha <= rd_data[3*CH_W +: CH_W];
                    end
                end
                S_DIV: begin
                    if (div_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata  <= {r_alpha, quot[2], quot[1], quot[0]};
                        m_axis_tlast  <= last;
                        r_state       <= S_IDLE;
                        if (last) begin
                            r_in_col   <= '0;
                            r_in_row   <= '0;
                            r_out_col  <= '0;
                            r_out_row  <= '0;
                            r_in_addr  <= '0;
                            r_out_addr <= '0;
                        end else begin
                            if ((CW+1)'(r_out_col) + (CW+1)'(1) >= w_eff) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + RW'(1);
                            end else begin
                                r_out_col <= r_out_col + CW'(1);
                            end
                            r_out_addr <= (r_out_addr == AW'(SLOTS - 1)) ? '0 :
                                          r_out_addr + AW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `GBU_ASSERT_IMP(a_read_bound, r_state == S_READ, r_k <= 5'd25)
    `GBU_ASSERT_IMP(a_div_state, div_done, r_state == S_DIV)
    `GBU_ASSERT_IMP(a_nonzero_den, div_start, r_total != '0)
    `GBU_ASSERT_IMP(a_out_behind_in, r_state == S_READ, r_out_row <= r_in_row)
endmodule
